@@ rtl/drx_pkg.sv @@
package drx_pkg;

  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned LengthWidth = 16;
  localparam int unsigned KindWidth   = 3;

  localparam logic [LengthWidth-1:0] MaxBodyLengthReset = 16'd4096;

  localparam logic [ByteWidth-1:0] CharDollar = 8'h24;
  localparam logic [ByteWidth-1:0] CharHash   = 8'h23;
  localparam logic [ByteWidth-1:0] CharPlus   = 8'h2B;
  localparam logic [ByteWidth-1:0] CharMinus  = 8'h2D;

  typedef enum logic [KindWidth-1:0] {
    EV_BODY = 3'd0,
    EV_GOOD = 3'd1,
    EV_BAD  = 3'd2,
    EV_ACK  = 3'd3,
    EV_RETX = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic                   emit;
    event_kind_t            kind;
    logic [ByteWidth-1:0]   body_byte;
    logic [LengthWidth-1:0] body_length;
  } drx_result_t;

endpackage

@@ rtl/drx_if.sv @@
interface drx_byte_if;
  import drx_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] link_byte;

  modport source (output valid, output link_byte, input ready);
  modport sink (input valid, input link_byte, output ready);
endinterface

interface drx_event_if;
  import drx_pkg::*;

  logic                   valid;
  logic                   ready;
  event_kind_t            event_kind;
  logic [ByteWidth-1:0]   body_byte;
  logic [LengthWidth-1:0] body_length;

  modport source (output valid, output event_kind, output body_byte, output body_length,
                  input ready);
  modport sink (input valid, input event_kind, input body_byte, input body_length,
                output ready);
endinterface

@@ rtl/drx_framer.sv @@
module drx_framer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [drx_pkg::ByteWidth-1:0]   link_byte,
  input  logic [drx_pkg::LengthWidth-1:0] max_body_length,
  output drx_pkg::drx_result_t            result
);
  import drx_pkg::*;

  typedef enum logic [1:0] {
    IDLE      = 2'd0,
    BODY      = 2'd1,
    CSUM_HIGH = 2'd2,
    CSUM_LOW  = 2'd3
  } phase_t;

  phase_t                 phase, phase_next;
  logic [ByteWidth-1:0]   running_sum, running_sum_next;
  logic [3:0]             high_nibble, high_nibble_next;
  logic [LengthWidth-1:0] length_count, length_count_next;
  logic                   error_flag, error_flag_next;
  logic [4:0]             hex;

  // Bit 4 marks a byte that is not a hex digit; the low four bits are then zero.
  function automatic logic [4:0] hex_decode(input logic [ByteWidth-1:0] c);
    logic [ByteWidth-1:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b0, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b0, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b0, d[3:0]};
    end
    return 5'b1_0000;
  endfunction

  assign hex = hex_decode(link_byte);

  always_comb begin
    phase_next        = phase;
    running_sum_next  = running_sum;
    high_nibble_next  = high_nibble;
    length_count_next = length_count;
    error_flag_next   = error_flag;
    result            = '{emit: 1'b0, kind: EV_BODY, body_byte: '0, body_length: '0};
    unique case (phase)
      IDLE: begin
        priority if (link_byte == CharPlus) begin
          result.emit = 1'b1;
          result.kind = EV_ACK;
        end else if (link_byte == CharMinus) begin
          result.emit = 1'b1;
          result.kind = EV_RETX;
        end else if (link_byte == CharDollar) begin
          phase_next        = BODY;
          running_sum_next  = '0;
          high_nibble_next  = '0;
          length_count_next = '0;
          error_flag_next   = 1'b0;
        end
      end
      BODY: begin
        priority if (link_byte == CharHash) begin
          phase_next = CSUM_HIGH;
        end else if (length_count >= max_body_length) begin
          // Bytes past the limit are dropped silently but spoil the packet.
          error_flag_next = 1'b1;
        end else begin
          running_sum_next  = running_sum + link_byte;
          length_count_next = length_count + 1'b1;
          result.emit       = 1'b1;
          result.kind       = EV_BODY;
          result.body_byte  = link_byte;
        end
      end
      CSUM_HIGH: begin
        high_nibble_next = hex[3:0];
        error_flag_next  = error_flag | hex[4];
        phase_next       = CSUM_LOW;
      end
      CSUM_LOW: begin
        phase_next         = IDLE;
        error_flag_next    = error_flag | hex[4];
        result.emit        = 1'b1;
        result.body_length = length_count;
        if (!error_flag && !hex[4] && {high_nibble, hex[3:0]} == running_sum) begin
          result.kind = EV_GOOD;
        end else begin
          result.kind = EV_BAD;
        end
      end
      default: begin
        phase_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= IDLE;
      running_sum  <= '0;
      high_nibble  <= '0;
      length_count <= '0;
      error_flag   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      running_sum  <= running_sum_next;
      high_nibble  <= high_nibble_next;
      length_count <= length_count_next;
      error_flag   <= error_flag_next;
    end
  end

endmodule

@@ rtl/debug_packet_receiver.sv @@
// Debugger link packet receiver. One link byte is taken per beat and at most one event
// comes out per byte, in the cycle after it is taken: acknowledge and retransmit requests
// outside a packet, each body byte of a '$' ... '#hh' packet up to the length limit, and a
// good or bad verdict with the body length once both checksum digits are in. A new byte can
// be accepted in every cycle, since the framing state updates once per accepted byte; the only
// stall is a held result in the output register, which blocks input until it is taken.
// The body length limit is written through cfg_write_enable/cfg_write_data and resets to 4096.
module debug_packet_receiver (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_enable,
  input  logic [drx_pkg::LengthWidth-1:0] cfg_write_data,
  drx_byte_if.sink                        link,
  drx_event_if.source                     events
);
  import drx_pkg::*;

  logic [LengthWidth-1:0] max_body_length;
  logic                   accept;
  drx_result_t            result;
  logic                   out_valid;
  event_kind_t            out_kind;
  logic [ByteWidth-1:0]   out_byte;
  logic [LengthWidth-1:0] out_length;

  assign link.ready = !out_valid || events.ready;
  assign accept     = link.valid && link.ready;

  drx_framer u_framer (
    .clk             (clk),
    .rst             (rst),
    .step            (accept),
    .link_byte       (link.link_byte),
    .max_body_length (max_body_length),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_length <= MaxBodyLengthReset;
    end else if (cfg_write_enable) begin
      max_body_length <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= result.emit;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result.emit) begin
      out_kind   <= result.kind;
      out_byte   <= result.body_byte;
      out_length <= result.body_length;
    end
  end

  assign events.valid       = out_valid;
  assign events.event_kind  = out_kind;
  assign events.body_byte   = out_byte;
  assign events.body_length = out_length;

endmodule

@@ rtl/drx_checker.sv @@
module drx_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            link_ready,
  input logic                            events_valid,
  input logic                            events_ready,
  input logic [drx_pkg::KindWidth-1:0]   event_kind,
  input logic [drx_pkg::ByteWidth-1:0]   body_byte,
  input logic [drx_pkg::LengthWidth-1:0] body_length
);
  import drx_pkg::*;

  // A result that is not taken stays on offer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    events_valid && !events_ready |=> events_valid)
    else $error("event beat dropped while stalled");

  // Input is only blocked by a result that waits to be taken.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !(events_valid && !events_ready) |-> link_ready)
    else $error("link not ready although output is free");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    events_valid && event_kind != EV_BODY |-> body_byte == '0)
    else $error("body byte set on a non-body event");

  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    events_valid && event_kind != EV_GOOD && event_kind != EV_BAD |-> body_length == '0)
    else $error("body length set on an event that does not end a packet");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    events_valid |-> event_kind <= EV_RETX)
    else $error("event kind out of range");

endmodule

bind debug_packet_receiver drx_checker u_drx_checker (
  .clk          (clk),
  .rst          (rst),
  .link_ready   (link.ready),
  .events_valid (events.valid),
  .events_ready (events.ready),
  .event_kind   (events.event_kind),
  .body_byte    (events.body_byte),
  .body_length  (events.body_length)
);
